FILE: hdl/multi_channel_reload_timer_bank_core_defines.svh
// Assertion helpers shared by the timer bank RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef MULTI_CHANNEL_RELOAD_TIMER_BANK_CORE_DEFINES_SVH
`define MULTI_CHANNEL_RELOAD_TIMER_BANK_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mcrt_pkg.sv
`default_nettype none

package mcrt_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_SET   = 3'd1;
    localparam logic [2:0] FUNC_KILL  = 3'd2;
    localparam logic [2:0] FUNC_TEST  = 3'd3;
    localparam logic [2:0] FUNC_READY = 3'd4;

    // Result kinds.
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    // Broadcast control from the sequencer to every timer cell.
    typedef struct packed {
        logic tick;        // count down all armed cells with a nonzero count
        logic set;         // arm the selected cell
        logic kill;        // disarm the selected cell
        logic cb;          // callback mode for a set
        logic load;        // place the scan token on the selected cell
        logic shift;       // move the token one cell up
        logic take_flag;   // clear the timeout flag under the token
        logic take_event;  // clear the pending event under the token
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/mcrt_cell.sv
`default_nettype none

module mcrt_cell
    import mcrt_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_ctl_t             ctl,
    input  wire logic                  sel,
    input  wire logic [COUNT_BITS-1:0] ival,
    input  wire logic                  tok_in,
    output logic                       tok,
    output logic                       rdy,
    output logic                       ev
);

    logic                  en_reg, en_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] rel_reg, rel_next;
    logic                  cbm_reg, cbm_next;
    logic                  flag_reg, flag_next;
    logic                  evp_reg, evp_next;
    logic                  tok_reg, tok_next;

    // Timer state update for one transaction or scan step.
    always_comb
    begin
        en_next   = en_reg;
        cnt_next  = cnt_reg;
        rel_next  = rel_reg;
        cbm_next  = cbm_reg;
        flag_next = flag_reg;
        evp_next  = evp_reg;

        if (ctl.set && sel)
        begin
            en_next   = 1'b1;
            cnt_next  = ival;
            rel_next  = ival;
            cbm_next  = ctl.cb;
            flag_next = 1'b0;
        end

        if (ctl.kill && sel)
        begin
            en_next = 1'b0;
        end

        // A count of one expires on this tick and reloads.
        if (ctl.tick && en_reg && (cnt_reg != '0))
        begin
            if (cnt_reg == COUNT_BITS'(1))
            begin
                cnt_next = rel_reg;
                if (cbm_reg)
                begin
                    evp_next = 1'b1;
                end
                else
                begin
                    flag_next = 1'b1;
                end
            end
            else
            begin
                cnt_next = cnt_reg - COUNT_BITS'(1);
            end
        end

        if (ctl.take_flag && tok_reg)
        begin
            flag_next = 1'b0;
        end

        if (ctl.take_event && tok_reg)
        begin
            evp_next = 1'b0;
        end
    end

    // On a load the token lands here or is cleared; on a shift it comes from the cell below; else it stays.
    always_comb
    begin
        tok_next = tok_reg;
        if (ctl.load)
        begin
            tok_next = sel;
        end
        else if (ctl.shift)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= 1'b0;
            cnt_reg  <= '0;
            rel_reg  <= '0;
            cbm_reg  <= 1'b0;
            flag_reg <= 1'b0;
            evp_reg  <= 1'b0;
            tok_reg  <= 1'b0;
        end
        else
        begin
            en_reg   <= en_next;
            cnt_reg  <= cnt_next;
            rel_reg  <= rel_next;
            cbm_reg  <= cbm_next;
            flag_reg <= flag_next;
            evp_reg  <= evp_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok = tok_reg;
    assign rdy = en_reg && flag_reg;
    assign ev  = evp_reg;

endmodule

`default_nettype wire

FILE: hdl/multi_channel_reload_timer_bank_core.sv
// Set and kill are applied on acceptance; test passes through a test state that emits its result.
// Get-ready walks a scan token up from the saved pointer, one timer cell per cycle.
// Tick walks the token up from cell zero to the last expiring callback timer.
// One transaction is in work at a time; results wait in an output register, and output stalls
// stall the sequencer. Reset (asynchronous, active low) disarms all timers, clears counts, flags,
// the pointer and the output register.
`default_nettype none

`include "multi_channel_reload_timer_bank_core_defines.svh"

module multi_channel_reload_timer_bank_core
    import mcrt_pkg::*;
#(
    parameter int NUM_TIMERS = 4,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [1:0]  timer_id,
    input  wire logic [31:0] interval,
    input  wire logic        use_callback,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [2:0]       which_timer,
    output logic             hit,
    output logic             last
);

    localparam int PW = $clog2(NUM_TIMERS + 1);
    localparam logic [PW-1:0] N_IDX = PW'(NUM_TIMERS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TEST  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EVENT = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   ptr_reg, ptr_next;
    logic [PW-1:0]   idx_reg, idx_next;
    logic [1:0]      id_reg, id_next;

    logic            out_valid_reg, out_valid_next;
    logic            kind_reg, hit_reg, last_reg;
    logic [2:0]      which_reg;

    cell_ctl_t               ctl;
    logic [NUM_TIMERS-1:0]   sel_vec;
    logic [NUM_TIMERS-1:0]   tok_vec;
    logic [NUM_TIMERS-1:0]   rdy_vec;
    logic [NUM_TIMERS-1:0]   ev_vec;
    logic [COUNT_BITS-1:0]   ival;

    logic            accept;
    logic            slot_free;
    logic            cur_rdy;
    logic            cur_ev;
    logic            others_ev;
    logic [PW-1:0]   ptr_wrap;

    logic            emit;
    logic            e_kind;
    logic [2:0]      e_which;
    logic            e_hit;
    logic            e_last;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign cur_rdy   = |(tok_vec & rdy_vec);
    assign cur_ev    = |(tok_vec & ev_vec);
    assign others_ev = |(ev_vec & ~tok_vec);
    assign ptr_wrap  = (ptr_reg >= N_IDX) ? '0 : ptr_reg;
    assign ival      = COUNT_BITS'(interval);

    // Cell select: the addressed timer, the scan start, or cell zero for a tick or other code.
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            unique case (func) inside
                FUNC_SET, FUNC_KILL, FUNC_TEST: sel_vec[i] = (int'(timer_id) == i);
                FUNC_READY:                     sel_vec[i] = (int'(ptr_wrap) == i);
                default:                        sel_vec[i] = (i == 0);
            endcase
        end
    end

    // Row of timer cells; the scan token climbs from each cell to the next.
    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_cell
        logic tok_in;
        if (g == 0)
        begin : g_first
            assign tok_in = 1'b0;
        end
        else
        begin : g_rest
            assign tok_in = tok_vec[g-1];
        end

        mcrt_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sel    (sel_vec[g]),
            .ival   (ival),
            .tok_in (tok_in),
            .tok    (tok_vec[g]),
            .rdy    (rdy_vec[g]),
            .ev     (ev_vec[g])
        );
    end

    // Sequencer: takes one transaction at a time, walks the token for get-ready and tick, and emits results.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        id_next    = id_reg;
        ctl        = '0;
        ctl.cb     = use_callback;
        emit       = 1'b0;
        e_kind     = KIND_ANSWER;
        e_which    = 3'(idx_reg);
        e_hit      = 1'b0;
        e_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_TICK:
                        begin
                            ctl.tick   = 1'b1;
                            ctl.load   = 1'b1;
                            idx_next   = '0;
                            state_next = S_EVENT;
                        end
                        FUNC_SET:
                        begin
                            ctl.set = 1'b1;
                        end
                        FUNC_KILL:
                        begin
                            ctl.kill = 1'b1;
                        end
                        FUNC_TEST:
                        begin
                            ctl.load   = 1'b1;
                            id_next    = timer_id;
                            state_next = S_TEST;
                        end
                        FUNC_READY:
                        begin
                            ctl.load   = 1'b1;
                            idx_next   = ptr_wrap;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TEST:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    e_which       = 3'(id_reg);
                    e_hit         = cur_rdy;
                    ctl.take_flag = cur_rdy;
                    state_next    = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if ((idx_reg == N_IDX) || cur_rdy)
                begin
                    // Either the token ran off the top or it sits on a ready timer.
                    if (slot_free)
                    begin
                        emit          = 1'b1;
                        e_hit         = cur_rdy;
                        ctl.take_flag = cur_rdy;
                        ptr_next      = idx_reg;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    ctl.shift = 1'b1;
                    idx_next  = idx_reg + PW'(1);
                end
            end

            S_EVENT:
            begin
                if (ev_vec == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (cur_ev)
                begin
                    if (slot_free)
                    begin
                        emit           = 1'b1;
                        e_kind         = KIND_EVENT;
                        e_last         = !others_ev;
                        ctl.take_event = 1'b1;
                        ctl.shift      = 1'b1;
                        idx_next       = idx_reg + PW'(1);
                        if (!others_ev)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    ctl.shift = 1'b1;
                    idx_next  = idx_reg + PW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register holds a result while the output is stalled.
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            id_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            id_reg        <= id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only when a new result is produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= 1'b0;
            which_reg <= '0;
            hit_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (emit)
        begin
            kind_reg  <= e_kind;
            which_reg <= e_which;
            hit_reg   <= e_hit;
            last_reg  <= e_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign which_timer = which_reg;
    assign hit         = hit_reg;
    assign last        = last_reg;

    // At most one cell holds the scan token.
    `MCRT_ASSERT_SAME(a_tok_onehot, 1'b1, $onehot0(tok_vec), "scan token in more than one cell")
    // The get-ready pointer never goes beyond one past the last timer.
    `MCRT_ASSERT_SAME(a_ptr_range, 1'b1, ptr_reg <= N_IDX, "scan pointer out of range")
    // Events are emitted in order, so none may remain once the token has left.
    `MCRT_ASSERT_SAME(a_ev_behind, (state_reg == S_EVENT) && (tok_vec == '0), ev_vec == '0,
                      "expiry event left behind the scan token")
    // An emitted result is presented on the next cycle.
    `MCRT_ASSERT_NEXT(a_emit_shows, emit, out_valid_reg, "emitted result not presented")

endmodule

`default_nettype wire

FILE: verif/tb_multi_channel_reload_timer_bank_core.sv
`default_nettype none

module tb_multi_channel_reload_timer_bank_core
    import mcrt_pkg::*;
();

    localparam int N_TMR       = 4;
    localparam int RAND_ITEMS  = 150;
    localparam int CALM_ITEMS  = 30;
    localparam int LONG_HOLD   = 120;
    localparam int DRAIN_WAIT  = 4 * N_TMR;

    // Func codes the block does not decode.
    localparam logic [2:0] FUNC_SPARE5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    localparam logic [2:0] NONE_READY = 3'(N_TMR);

    typedef struct packed {
        logic       kind;
        logic [2:0] which;
        logic       hit;
        logic       last;
    } timer_result_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [1:0]    id;
        logic [31:0]   ival;
        logic          cb;
        logic          typed;
        timer_result_t want;
    } stim_row_t;

    localparam timer_result_t NO_WANT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = FUNC_TICK;
    logic [1:0]  timer_id = 2'd0;
    logic [31:0] interval = 32'd0;
    logic        use_callback = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [2:0]  which_timer;
    logic        hit;
    logic        last;

    // Shadow copy of the timer bank.
    bit          tmr_armed  [N_TMR];
    bit [31:0]   tmr_count  [N_TMR];
    bit [31:0]   tmr_reload [N_TMR];
    bit          tmr_cb     [N_TMR];
    bit          tmr_flag   [N_TMR];
    bit [2:0]    scan_ptr;

    timer_result_t step_out[$];
    timer_result_t due_results[$];
    int          mismatch_count = 0;
    bit          calm = 1'b0;
    bit          hold_long = 1'b0;

    // Directed table: typed expectations only for the obvious answers.
    stim_row_t dir_rows [23] = '{
        '{FUNC_TEST,   2'd0, 32'd0,        1'b0, 1'b1, '{KIND_ANSWER, 3'd0, 1'b0, 1'b1}},
        '{FUNC_READY,  2'd0, 32'd0,        1'b0, 1'b1, '{KIND_ANSWER, NONE_READY, 1'b0, 1'b1}},
        '{FUNC_TICK,   2'd3, 32'hFFFFFFFF, 1'b1, 1'b0, NO_WANT},
        '{FUNC_SPARE5, 2'd1, 32'd7,        1'b1, 1'b0, NO_WANT},
        '{FUNC_SPARE6, 2'd2, 32'hA5A5A5A5, 1'b0, 1'b0, NO_WANT},
        '{FUNC_SPARE7, 2'd3, 32'hFFFFFFFF, 1'b1, 1'b0, NO_WANT},
        '{FUNC_SET,    2'd0, 32'd1,        1'b1, 1'b0, NO_WANT},
        '{FUNC_SET,    2'd1, 32'd2,        1'b0, 1'b0, NO_WANT},
        '{FUNC_SET,    2'd2, 32'd0,        1'b1, 1'b0, NO_WANT},
        '{FUNC_SET,    2'd3, 32'hFFFFFFFF, 1'b1, 1'b0, NO_WANT},
        '{FUNC_TICK,   2'd0, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_TICK,   2'd0, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_TEST,   2'd1, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_TEST,   2'd1, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_TICK,   2'd0, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_TICK,   2'd0, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_KILL,   2'd1, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_TEST,   2'd1, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_READY,  2'd0, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_SET,    2'd2, 32'd1,        1'b1, 1'b0, NO_WANT},
        '{FUNC_TICK,   2'd0, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_KILL,   2'd0, 32'd0,        1'b0, 1'b0, NO_WANT},
        '{FUNC_READY,  2'd0, 32'd0,        1'b0, 1'b0, NO_WANT}
    };

    multi_channel_reload_timer_bank_core #(
        .NUM_TIMERS(N_TMR),
        .COUNT_BITS(32)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .timer_id(timer_id),
        .interval(interval),
        .use_callback(use_callback),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .which_timer(which_timer),
        .hit(hit),
        .last(last)
    );

    // Clock generation.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Applies one operation to the shadow bank and leaves its results in step_out.
    function automatic void timer_bank_step(logic [2:0] op, logic [1:0] id,
                                            logic [31:0] ival, logic cb);
        timer_result_t r;
        bit found;
        found = 1'b0;
        step_out.delete();
        case (op)
            FUNC_TICK:
            begin
                for (int i = 0; i < N_TMR; i++)
                begin
                    if (tmr_armed[i] && tmr_count[i] != 0)
                    begin
                        tmr_count[i] = tmr_count[i] - 1;
                        if (tmr_count[i] == 0)
                        begin
                            if (tmr_cb[i])
                            begin
                                r = '{KIND_EVENT, 3'(i), 1'b0, 1'b0};
                                step_out.push_back(r);
                            end
                            else
                            begin
                                tmr_flag[i] = 1'b1;
                            end
                            tmr_count[i] = tmr_reload[i];
                        end
                    end
                end
                if (step_out.size() > 0)
                begin
                    r = step_out.pop_back();
                    r.last = 1'b1;
                    step_out.push_back(r);
                end
            end
            FUNC_SET:
            begin
                tmr_armed[id]  = 1'b1;
                tmr_count[id]  = ival;
                tmr_reload[id] = ival;
                tmr_cb[id]     = cb;
                tmr_flag[id]   = 1'b0;
            end
            FUNC_KILL:
            begin
                tmr_armed[id] = 1'b0;
            end
            FUNC_TEST:
            begin
                if (tmr_armed[id] && tmr_flag[id])
                begin
                    tmr_flag[id] = 1'b0;
                    found = 1'b1;
                end
                r = '{KIND_ANSWER, {1'b0, id}, found, 1'b1};
                step_out.push_back(r);
            end
            FUNC_READY:
            begin
                // The pointer wraps only when a previous scan ran off the end.
                if (scan_ptr >= N_TMR)
                    scan_ptr = 3'd0;
                while (scan_ptr < N_TMR && !found)
                begin
                    if (tmr_armed[scan_ptr] && tmr_flag[scan_ptr])
                    begin
                        tmr_flag[scan_ptr] = 1'b0;
                        found = 1'b1;
                    end
                    else
                    begin
                        scan_ptr = scan_ptr + 3'd1;
                    end
                end
                r = '{KIND_ANSWER, scan_ptr, found, 1'b1};
                step_out.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offers one transaction, waits for it to be taken and queues what it must produce.
    task automatic offer_item(logic [2:0] op, logic [1:0] id, logic [31:0] ival,
                              logic cb, logic typed, timer_result_t want);
        in_valid     <= 1'b1;
        func         <= op;
        timer_id     <= id;
        interval     <= ival;
        use_callback <= cb;
        do @(posedge clk); while (in_stall);
        timer_bank_step(op, id, ival, cb);
        if (typed)
            due_results.push_back(want);
        else
            foreach (step_out[k])
                due_results.push_back(step_out[k]);
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender: reset, directed table, then the random mix.
    initial
    begin
        int          counted;
        int          w;
        bit          held_once;
        bit          drained_once;
        logic [2:0]  op;
        logic [31:0] ival;
        counted = 0;
        held_once = 1'b0;
        drained_once = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if ($urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 18));
            offer_item(dir_rows[k].op, dir_rows[k].id, dir_rows[k].ival, dir_rows[k].cb,
                       dir_rows[k].typed, dir_rows[k].want);
        end

        while (counted < RAND_ITEMS)
        begin
            w = $urandom_range(0, 99);
            if (w < 38)
                op = FUNC_TICK;
            else if (w < 56)
                op = FUNC_SET;
            else if (w < 64)
                op = FUNC_KILL;
            else if (w < 79)
                op = FUNC_TEST;
            else if (w < 96)
                op = FUNC_READY;
            else
                op = 3'($urandom_range(FUNC_SPARE5, FUNC_SPARE7));

            // Mostly short intervals so that timers expire often.
            w = $urandom_range(0, 99);
            if (w < 10)
                ival = 32'd0;
            else if (w < 70)
                ival = $urandom_range(1, 4);
            else if (w < 85)
                ival = $urandom_range(5, 20);
            else
                ival = $urandom();

            // Let the receiver back up while items keep coming.
            if (counted == 60 && !held_once)
            begin
                hold_long = 1'b1;
                held_once = 1'b1;
            end

            // Let the bank run dry once before going on.
            if (counted == 110 && !drained_once)
            begin
                drained_once = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (due_results.size() != 0);
            end

            calm = (counted >= RAND_ITEMS - CALM_ITEMS);
            if (!calm && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 18));
            offer_item(op, 2'($urandom_range(0, 3)), ival, 1'($urandom_range(0, 1)),
                       1'b0, NO_WANT);
            if (op <= FUNC_READY)
                counted++;
        end

        // Drain and close out.
        in_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial
    begin
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(30, 60)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    // Result checker: each taken result against the oldest expectation.
    always @(posedge clk)
    begin
        timer_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d which_timer %0d hit %0d last %0d",
                       kind, which_timer, hit, last);
                mismatch_count++;
            end
            else
            begin
                exp_r = due_results.pop_front();
                if (kind !== exp_r.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, kind);
                    mismatch_count++;
                end
                if (which_timer !== exp_r.which)
                begin
                    $error("which_timer: expected %0d, actual %0d", exp_r.which, which_timer);
                    mismatch_count++;
                end
                if (hit !== exp_r.hit)
                begin
                    $error("hit: expected %0d, actual %0d", exp_r.hit, hit);
                    mismatch_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_r.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: multi_channel_reload_timer_bank_core.f
+incdir+hdl
hdl/mcrt_pkg.sv
hdl/mcrt_cell.sv
hdl/multi_channel_reload_timer_bank_core.sv
verif/tb_multi_channel_reload_timer_bank_core.sv
